### src/rpe_pkg.sv
// Shared constants, types and elaboration-time table builders for the rotary embedding unit.
package rpe_pkg;

  localparam int EMBED_DIM    = 128;
  localparam int THETA        = 10000;
  localparam int CORDIC_STEPS = 16;

  localparam int ELEM_W      = 16;
  localparam int IDX_W       = 6;
  localparam int POS_W       = 20;
  localparam int ROM_DEPTH   = 64;
  localparam int FREQ_W      = 40;
  localparam int PHASE_W     = 40;
  localparam int GUARD_BITS  = 16;
  localparam int DATA_W      = 36;
  localparam int ANGLE_W     = 40;
  localparam int GAIN_W      = 28;
  localparam int PROD_W      = DATA_W + GAIN_W + 1;
  localparam int ROUND_SHIFT = 44;
  localparam int RES_W       = PROD_W - ROUND_SHIFT;

  localparam logic [63:0] INV_2PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0] LN2_Q64     = 64'hB17217F7D1CF79AC;

  localparam logic signed [ANGLE_W-1:0] EIGHTH_TURN = 40'sh20_0000_0000;
  localparam logic signed [PROD_W-1:0]  ROUND_HALF  = PROD_W'(64'd1 << (ROUND_SHIFT - 1));
  localparam logic signed [ELEM_W-1:0]  ELEM_MAX    = 16'sh7FFF;
  localparam logic signed [ELEM_W-1:0]  ELEM_MIN    = 16'sh8000;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  // vector pair and residual angle carried through the rotator
  typedef struct packed {
    logic signed [DATA_W-1:0]  x;
    logic signed [DATA_W-1:0]  y;
    logic signed [ANGLE_W-1:0] z;
  } rot_t;

  typedef logic [ROM_DEPTH-1:0][FREQ_W-1:0]     freq_rom_t;
  typedef logic [CORDIC_STEPS-1:0][ANGLE_W-1:0] atan_table_t;

  // ---- elaboration-time arithmetic on 64-bit words ----

  function automatic logic [127:0] mul_full(input logic [63:0] a, input logic [63:0] b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = mul_full(a, b);
    return p[127:64];
  endfunction

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = mul_full(a, b);
    return p[125:62];
  endfunction

  // restoring division, quotient truncated
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] round_shift_u(input logic [63:0] v, input int s);
    if (s >= 64) return 64'd0;
    if (s == 0) return v;
    return ((v >> (s - 1)) + 64'd1) >> 1;
  endfunction

  // log2(THETA) in Q48 by repeated squaring of the mantissa
  function automatic logic [63:0] log2_theta_q48();
    logic [63:0] t;
    logic [63:0] m;
    logic [63:0] res;
    logic [63:0] sq;
    int n;
    t = (THETA < 1) ? 64'd1 : 64'(THETA);
    n = 0;
    for (int j = 1; j < 64; j++) begin
      if ((t >> j) != 64'd0) n = j;
    end
    m   = t << (62 - n);
    res = 64'(n) << 48;
    for (int k = 1; k <= 48; k++) begin
      sq = mul_q62(m, m);
      if (sq[63]) begin
        res[48-k] = 1'b1;
        m         = sq >> 1;
      end else begin
        m = sq;
      end
    end
    return res;
  endfunction

  // e^-y, Q62, Taylor series until a term vanishes
  function automatic logic [63:0] exp_neg_q62(input logic [63:0] y);
    logic [63:0] sum;
    logic [63:0] t;
    logic        done;
    sum  = 64'd1 << 62;
    t    = 64'd1 << 62;
    done = 1'b0;
    for (int n = 1; n < 40; n++) begin
      if (!done) begin
        t = udiv64(mul_q62(t, y), 64'(n));
        if (t == 64'd0) done = 1'b1;
        else if (n[0]) sum = sum - t;
        else sum = sum + t;
      end
    end
    return sum;
  endfunction

  function automatic freq_rom_t build_freq_rom();
    freq_rom_t   rom;
    logic [63:0] dim;
    logic [63:0] lg;
    logic [63:0] x;
    logic [63:0] q;
    logic [63:0] f;
    logic [63:0] y;
    logic [63:0] v;
    dim = (EMBED_DIM < 1) ? 64'd1 : 64'(EMBED_DIM);
    lg  = log2_theta_q48();
    for (int i = 0; i < ROM_DEPTH; i++) begin
      x = udiv64(lg * 64'(2 * i), dim);
      q = x >> 48;
      f = x & ((64'd1 << 48) - 64'd1);
      y = mul_hi(f << 16, LN2_Q64) >> 2;
      v = mul_hi(exp_neg_q62(y), INV_2PI_Q64);
      if (q > 64'd64) rom[i] = '0;
      else rom[i] = FREQ_W'(round_shift_u(v, 22 + int'(q)));
    end
    return rom;
  endfunction

  // atan(2^-k) in Q0.40 turns
  function automatic atan_table_t build_atan_table();
    atan_table_t tab;
    logic [63:0] rad;
    logic [63:0] term;
    logic [63:0] e;
    tab[0] = ANGLE_W'(64'd1 << 37);
    for (int k = 1; k < CORDIC_STEPS; k++) begin
      rad = '0;
      for (int n = 0; n < 32; n++) begin
        e = 64'(k * (2 * n + 1));
        if (e <= 64'd62) begin
          term = udiv64(64'd1 << (64'd62 - e), 64'(2 * n + 1));
          if (n[0]) rad = rad - term;
          else rad = rad + term;
        end
      end
      tab[k] = ANGLE_W'(round_shift_u(mul_hi(rad, INV_2PI_Q64), 22));
    end
    return tab;
  endfunction

  // CORDIC gain correction, Q28
  function automatic logic [GAIN_W-1:0] build_gain();
    logic [63:0] k2;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    k2 = 64'd1 << 62;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      k2 = k2 - udiv64(k2, (64'd1 << (2 * k)) + 64'd1);
    end
    v = k2 >> 6;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > v) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return GAIN_W'(r);
  endfunction

  localparam freq_rom_t          FREQ_ROM    = build_freq_rom();
  localparam atan_table_t        ATAN_TABLE  = build_atan_table();
  localparam logic [GAIN_W-1:0]  GAIN_Q28    = build_gain();

endpackage

### src/rpe_cordic.sv
// Pipelined CORDIC rotator, one micro-rotation per register stage.
module rpe_cordic (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rpe_pkg::rot_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rpe_pkg::rot_t out_data_o
);
  import rpe_pkg::*;

  logic [CORDIC_STEPS-1:0] valid_q;
  logic [CORDIC_STEPS-1:0] stage_en;
  rot_t                    stage_q [CORDIC_STEPS];
  rot_t                    stage_d [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam int K = k;
    localparam logic signed [ANGLE_W-1:0] ATAN_K = ATAN_TABLE[k];

    logic                      prev_valid;
    logic                      next_en;
    logic signed [DATA_W-1:0]  x_in;
    logic signed [DATA_W-1:0]  y_in;
    logic signed [ANGLE_W-1:0] z_in;
    logic signed [DATA_W-1:0]  dx;
    logic signed [DATA_W-1:0]  dy;

    if (k == 0) begin : g_first
      assign prev_valid = in_valid_i;
      assign x_in       = in_data_i.x;
      assign y_in       = in_data_i.y;
      assign z_in       = in_data_i.z;
    end else begin : g_next
      assign prev_valid = valid_q[k-1];
      assign x_in       = stage_q[k-1].x;
      assign y_in       = stage_q[k-1].y;
      assign z_in       = stage_q[k-1].z;
    end

    if (k == CORDIC_STEPS - 1) begin : g_last
      assign next_en = out_ready_i;
    end else begin : g_mid
      assign next_en = stage_en[k+1];
    end

    // a stage moves when it is empty or its successor moves
    assign stage_en[k] = !valid_q[k] || next_en;

    assign dx = y_in >>> K;
    assign dy = x_in >>> K;

    always_comb begin
      if (!z_in[ANGLE_W-1]) begin
        stage_d[k].x = x_in - dx;
        stage_d[k].y = y_in + dy;
        stage_d[k].z = z_in - ATAN_K;
      end else begin
        stage_d[k].x = x_in + dx;
        stage_d[k].y = y_in - dy;
        stage_d[k].z = z_in + ATAN_K;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stage_en[k]) begin
        valid_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_en[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[CORDIC_STEPS-1];
  assign out_data_o  = stage_q[CORDIC_STEPS-1];

endmodule

### src/rotary_position_embedding_unit.sv
// Rotary position embedding: per-pair phase lookup, CORDIC rotation, gain and saturation.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+-----------
//  s_axis   | in  | first_value, second_value, pair_number,     | -
//           |     | token_position, zero pad to 64 bits         |
//  m_axis   | out | rotated_first, rotated_second               | saturated
//
// Throughput is one request per clock while m_axis_tready does not stall the
// pipeline. Stages in order: ROM read, phase multiply, quadrant fold,
// one stage per CORDIC micro-rotation, gain multiply, round and clip.
// Every stage carries its own valid bit and advances when it is empty or its
// successor advances, so bubbles are squeezed out and new requests keep
// entering while a finished result waits on m_axis_tready, until all stages fill.
// rst_ni clears only the valid bits; the frequency and angle tables are
// constants built at elaboration, so no warm-up is needed after reset.
module rotary_position_embedding_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] first_value, [31:16] second_value, [37:32] pair_number,
  // [57:38] token_position, [63:58] zero
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] rotated_first, [31:16] rotated_second
  output logic [31:0] m_axis_tdata,
  // [0] saturated
  output logic        m_axis_tuser
);
  import rpe_pkg::*;

  // stage enables, front to back
  logic en_p1, en_p2, en_p3, en_g1, en_g2;

  // P1: operands captured, frequency looked up
  logic                     v_p1_q;
  logic signed [ELEM_W-1:0] a_p1_q, b_p1_q;
  logic [POS_W-1:0]         pos_p1_q;
  logic [FREQ_W-1:0]        freq_p1_q;

  // P2: phase in turns (wraps modulo one turn)
  logic                       v_p2_q;
  logic signed [ELEM_W-1:0]   a_p2_q, b_p2_q;
  logic [PHASE_W-1:0]         phase_p2_q;
  logic [POS_W+FREQ_W-1:0]    phase_full;

  // P3: quarter-turn folded pair and residual angle
  logic                     v_p3_q;
  rot_t                     p3_q, p3_d;
  logic [1:0]               quad;
  logic signed [DATA_W-1:0] a_ext, b_ext;

  // CORDIC hookup
  logic cord_in_ready, cord_out_valid;
  rot_t cord_out;

  // G1: gain products
  logic                     v_g1_q;
  logic signed [PROD_W-1:0] px_g1_q, py_g1_q, px_d, py_d;
  logic signed [GAIN_W:0]   gain_s;

  // G2: output register
  logic                     v_g2_q;
  logic [ELEM_W:0]          rf_d, rs_d;
  logic signed [ELEM_W-1:0] rf_q, rs_q;
  logic                     sat_q;

  // round half up, drop the Q28 gain and guard bits, clip to 16 bits
  // returns {clip, value}
  function automatic logic [ELEM_W:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [RES_W-1:0]  r;
    s = p + ROUND_HALF;
    r = s[PROD_W-1:ROUND_SHIFT];
    if (!r[RES_W-1] && (|r[RES_W-2:ELEM_W-1])) begin
      return {1'b1, ELEM_MAX};
    end else if (r[RES_W-1] && !(&r[RES_W-2:ELEM_W-1])) begin
      return {1'b1, ELEM_MIN};
    end
    return {1'b0, r[ELEM_W-1:0]};
  endfunction

  assign en_p1 = !v_p1_q || en_p2;
  assign en_p2 = !v_p2_q || en_p3;
  assign en_p3 = !v_p3_q || cord_in_ready;
  assign en_g1 = !v_g1_q || en_g2;
  assign en_g2 = !v_g2_q || m_axis_tready;

  assign s_axis_tready = en_p1;

  // ---- P2 datapath: only the low 40 bits of the product matter ----
  assign phase_full = pos_p1_q * freq_p1_q;

  // ---- P3 datapath: quarter-turn fold ----
  // residual of 1/8 turn or more rolls into the next quadrant; sign-extending
  // the low 38 bits yields the residual in [-1/8, 1/8) turn directly
  assign quad   = phase_p2_q[PHASE_W-1:PHASE_W-2] + {1'b0, phase_p2_q[PHASE_W-3]};
  assign a_ext  = {{(DATA_W-ELEM_W-GUARD_BITS){a_p2_q[ELEM_W-1]}}, a_p2_q, {GUARD_BITS{1'b0}}};
  assign b_ext  = {{(DATA_W-ELEM_W-GUARD_BITS){b_p2_q[ELEM_W-1]}}, b_p2_q, {GUARD_BITS{1'b0}}};

  always_comb begin
    p3_d.z = {{2{phase_p2_q[PHASE_W-3]}}, phase_p2_q[PHASE_W-3:0]};
    unique case (quad_e'(quad))
      QUAD_0: begin
        p3_d.x = a_ext;
        p3_d.y = b_ext;
      end
      QUAD_1: begin
        p3_d.x = -b_ext;
        p3_d.y = a_ext;
      end
      QUAD_2: begin
        p3_d.x = -a_ext;
        p3_d.y = -b_ext;
      end
      QUAD_3: begin
        p3_d.x = b_ext;
        p3_d.y = -a_ext;
      end
      default: begin
        p3_d.x = a_ext;
        p3_d.y = b_ext;
      end
    endcase
  end

  rpe_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_p3_q),
    .in_ready_o  (cord_in_ready),
    .in_data_i   (p3_q),
    .out_valid_o (cord_out_valid),
    .out_ready_i (en_g1),
    .out_data_o  (cord_out)
  );

  // ---- G1 datapath: gain correction ----
  assign gain_s = {1'b0, GAIN_Q28};
  assign px_d   = cord_out.x * gain_s;
  assign py_d   = cord_out.y * gain_s;

  // ---- G2 datapath ----
  assign rf_d = round_sat(px_g1_q);
  assign rs_d = round_sat(py_g1_q);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p1_q <= 1'b0;
      v_p2_q <= 1'b0;
      v_p3_q <= 1'b0;
      v_g1_q <= 1'b0;
      v_g2_q <= 1'b0;
    end else begin
      if (en_p1) v_p1_q <= s_axis_tvalid;
      if (en_p2) v_p2_q <= v_p1_q;
      if (en_p3) v_p3_q <= v_p2_q;
      if (en_g1) v_g1_q <= cord_out_valid;
      if (en_g2) v_g2_q <= v_g1_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_p1) begin
      a_p1_q    <= s_axis_tdata[15:0];
      b_p1_q    <= s_axis_tdata[31:16];
      pos_p1_q  <= s_axis_tdata[57:38];
      freq_p1_q <= FREQ_ROM[s_axis_tdata[37:32]];
    end
    if (en_p2) begin
      a_p2_q     <= a_p1_q;
      b_p2_q     <= b_p1_q;
      phase_p2_q <= phase_full[PHASE_W-1:0];
    end
    if (en_p3) begin
      p3_q <= p3_d;
    end
    if (en_g1) begin
      px_g1_q <= px_d;
      py_g1_q <= py_d;
    end
    if (en_g2) begin
      rf_q  <= rf_d[ELEM_W-1:0];
      rs_q  <= rs_d[ELEM_W-1:0];
      sat_q <= rf_d[ELEM_W] || rs_d[ELEM_W];
    end
  end

  assign m_axis_tvalid = v_g2_q;
  assign m_axis_tdata  = {rs_q, rf_q};
  assign m_axis_tuser  = sat_q;

`ifndef ASSERT_OFF
  // a flagged result must sit on a rail in at least one lane
  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_g2_q && sat_q) |-> (rf_q == ELEM_MAX || rf_q == ELEM_MIN ||
                           rs_q == ELEM_MAX || rs_q == ELEM_MIN))
    else $error("saturation flag set on an unclipped result");

  // an empty front stage always takes a request
  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_p1_q |-> s_axis_tready)
    else $error("input stalled with an empty front stage");

  // quadrant fold leaves the residual within one eighth turn
  a_residual_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_p3_q |-> (p3_q.z >= -EIGHTH_TURN && p3_q.z < EIGHTH_TURN))
    else $error("CORDIC residual angle out of range");
`endif

endmodule
